### sv/positional_array_list_macros.svh
// ----------------------------------------------------------------------------
// positional_array_list_macros
// assertion macros used by the list datapath; they expect clk and rst in scope
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// property that must hold at every edge out of reset
`define PAL_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("positional_array_list: invariant violated");

// consequence that must hold in the cycle after the trigger
`define PAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional_array_list: sequence check failed");

`endif

### sv/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// sizes, codes and controller/datapath interface types of the positional list
// ----------------------------------------------------------------------------
package pal_pkg;

  // list sizing
  localparam int CAPACITY = 128;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // word field widths
  localparam int ACT_W  = 2;
  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int ST_W   = 3;

  // width for comparing positions against the fill count
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic start;      // check cycle: read at position, set up pointer
    logic err_res;    // result takes the check error
    logic grab;       // result takes the entry just read
    logic shift;      // one move of the shift
    logic scan;       // one step of the search
    logic write_val;  // store inserted value, count up
    logic del_done;   // count down after a delete
    logic out_load;   // move result into the output register
  } pal_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    action_t act;
    logic    chk_ok;
    logic    moves_none;
    logic    shift_last;
    logic    scan_hit;
    logic    scan_miss;
  } pal_stat_t;

endpackage

### sv/pal_dp.sv
// ----------------------------------------------------------------------------
// pal_dp
// list storage, fill count, shift and search pointers, result and output words
// ----------------------------------------------------------------------------
`include "positional_array_list_macros.svh"

module pal_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [pal_pkg::ACT_W-1:0]            action,
  input  logic signed [pal_pkg::DATA_W-1:0]    value,
  input  logic [pal_pkg::POS_W-1:0]            position,
  input  pal_pkg::pal_cmd_t                    cmd,
  output pal_pkg::pal_stat_t                   stat,
  output logic [pal_pkg::ST_W-1:0]             status,
  output logic signed [pal_pkg::DATA_W-1:0]    data,
  output logic [pal_pkg::POS_W-1:0]            where,
  output logic [pal_pkg::POS_W-1:0]            fill
);

  localparam int IDX_W  = pal_pkg::IDX_W;
  localparam int CNT_W  = pal_pkg::CNT_W;
  localparam int CMP_W  = pal_pkg::CMP_W;
  localparam int DATA_W = pal_pkg::DATA_W;
  localparam int POS_W  = pal_pkg::POS_W;

  logic [DATA_W-1:0]   mem [pal_pkg::CAPACITY];

  pal_pkg::action_t    act_q;
  logic [DATA_W-1:0]   val_q;
  logic [POS_W-1:0]    pos_q;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    ptr;
  logic [CNT_W-1:0]    ptr_init;
  logic                wpend;
  logic [IDX_W-1:0]    wa;
  logic                cmp_valid;
  logic [IDX_W-1:0]    cmp_idx;
  logic [CNT_W-1:0]    hit_pos;
  logic [DATA_W-1:0]   rd_data;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;

  pal_pkg::status_t    chk_status;
  pal_pkg::status_t    res_status;
  logic [DATA_W-1:0]   res_data;
  logic [POS_W-1:0]    res_where;

  logic [CMP_W-1:0]    pos_w;
  logic [CMP_W-1:0]    cnt_w;
  logic [CMP_W-1:0]    ptr_w;
  logic [CMP_W-1:0]    pos_m1;
  logic                scan_issue;

  // widened operands for position checks
  assign pos_w      = CMP_W'(pos_q);
  assign cnt_w      = CMP_W'(count);
  assign ptr_w      = CMP_W'(ptr);
  assign pos_m1     = pos_w - 1'b1;
  assign scan_issue = cnt_w > ptr_w;
  assign hit_pos    = CNT_W'(cmp_idx) + 1'b1;

  // error check of the held word, full and empty ahead of position
  always_comb begin
    chk_status = pal_pkg::ST_OK;
    case (act_q)
      pal_pkg::ACT_INSERT: begin
        if (count == CNT_W'(pal_pkg::CAPACITY)) begin
          chk_status = pal_pkg::ST_FULL;
        end else if (pos_w == '0 || pos_w > cnt_w + 1'b1) begin
          chk_status = pal_pkg::ST_BADPOS;
        end
      end
      pal_pkg::ACT_SEARCH: begin
        if (count == '0) begin
          chk_status = pal_pkg::ST_EMPTY;
        end
      end
      default: begin
        if (count == '0) begin
          chk_status = pal_pkg::ST_EMPTY;
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          chk_status = pal_pkg::ST_BADPOS;
        end
      end
    endcase
  end

  // shift bounds and pointer start per action
  always_comb begin
    stat.act        = act_q;
    stat.chk_ok     = (chk_status == pal_pkg::ST_OK);
    stat.moves_none = 1'b0;
    stat.shift_last = 1'b0;
    ptr_init        = '0;
    case (act_q)
      pal_pkg::ACT_INSERT: begin
        stat.moves_none = (pos_w == cnt_w + 1'b1);
        stat.shift_last = (ptr_w == pos_w);
        ptr_init        = count;
      end
      pal_pkg::ACT_DELETE: begin
        stat.moves_none = (pos_w == cnt_w);
        stat.shift_last = (ptr_w + 2'd2 == cnt_w);
        ptr_init        = CNT_W'(pos_m1);
      end
      default: begin
        ptr_init = '0;
      end
    endcase
    stat.scan_hit  = cmp_valid && (rd_data == val_q);
    stat.scan_miss = !cmp_valid && !scan_issue;
  end

  // read port address
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = IDX_W'(pos_m1);
    if (cmd.start) begin
      rd_en = 1'b1;
    end else if (cmd.shift) begin
      rd_en   = 1'b1;
      rd_addr = (act_q == pal_pkg::ACT_INSERT) ? IDX_W'(ptr - 1'b1) : IDX_W'(ptr + 1'b1);
    end else if (cmd.scan && scan_issue) begin
      rd_en   = 1'b1;
      rd_addr = ptr[IDX_W-1:0];
    end
  end

  // list storage: one write, one registered read a cycle
  always_ff @(posedge clk) begin
    if (wpend) begin
      mem[wa] <= rd_data;
    end else if (cmd.write_val) begin
      mem[IDX_W'(pos_m1)] <= val_q;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // input word capture and pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= pal_pkg::action_t'(action);
      val_q <= $unsigned(value);
      pos_q <= position;
    end
    if (cmd.start) begin
      ptr <= ptr_init;
    end else if (cmd.shift) begin
      ptr <= (act_q == pal_pkg::ACT_INSERT) ? ptr - 1'b1 : ptr + 1'b1;
    end else if (cmd.scan && scan_issue) begin
      ptr <= ptr + 1'b1;
    end
    if (cmd.shift) begin
      wa <= ptr[IDX_W-1:0];
    end
    if (cmd.scan && scan_issue) begin
      cmp_idx <= ptr[IDX_W-1:0];
    end
  end

  // fill count and pending flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      wpend     <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      wpend <= cmd.shift;
      if (cmd.start) begin
        cmp_valid <= 1'b0;
      end else if (cmd.scan) begin
        cmp_valid <= scan_issue;
      end
      if (cmd.write_val) begin
        count <= count + 1'b1;
      end else if (cmd.del_done) begin
        count <= count - 1'b1;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.err_res) begin
      res_status <= chk_status;
      res_data   <= '0;
      res_where  <= '0;
    end else if (cmd.grab) begin
      res_status <= pal_pkg::ST_OK;
      res_data   <= rd_data;
      res_where  <= pos_q;
    end else if (cmd.write_val) begin
      res_status <= pal_pkg::ST_OK;
      res_data   <= val_q;
      res_where  <= pos_q;
    end else if (cmd.scan && stat.scan_hit) begin
      res_status <= pal_pkg::ST_OK;
      res_data   <= val_q;
      res_where  <= POS_W'(hit_pos);
    end else if (cmd.scan && stat.scan_miss) begin
      res_status <= pal_pkg::ST_NOTFOUND;
      res_data   <= '0;
      res_where  <= '0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= res_status;
      data   <= $signed(res_data);
      where  <= res_where;
      fill   <= POS_W'(count);
    end
  end

  `PAL_ASSERT_ALWAYS(a_count_range, count <= CNT_W'(pal_pkg::CAPACITY))
  `PAL_ASSERT_ALWAYS(a_one_writer, !(wpend && cmd.write_val))
  `PAL_ASSERT_NEXT(a_insert_grows, cmd.write_val, count == CNT_W'($past(count) + 1'b1))
  `PAL_ASSERT_NEXT(a_err_clear, cmd.err_res, res_data == '0 && res_where == '0)

endmodule

### sv/pal_ctrl.sv
// ----------------------------------------------------------------------------
// pal_ctrl
// sequencer for check, shift, search and result hand-off of each word
// ----------------------------------------------------------------------------
module pal_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pal_pkg::pal_stat_t stat,
  output pal_pkg::pal_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_GRAB  = 8'b0000_0100,
    S_SHIFT = 8'b0000_1000,
    S_DRAIN = 8'b0001_0000,
    S_PUT   = 8'b0010_0000,
    S_SCAN  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.start = 1'b1;
        if (!stat.chk_ok) begin
          cmd.err_res = 1'b1;
          state_next  = S_DONE;
        end else begin
          case (stat.act)
            pal_pkg::ACT_INSERT: state_next = stat.moves_none ? S_PUT : S_SHIFT;
            pal_pkg::ACT_DELETE: state_next = S_GRAB;
            pal_pkg::ACT_READ:   state_next = S_GRAB;
            default:             state_next = S_SCAN;
          endcase
        end
      end
      S_GRAB: begin
        cmd.grab = 1'b1;
        if (stat.act == pal_pkg::ACT_READ) begin
          state_next = S_DONE;
        end else if (stat.moves_none) begin
          state_next = S_DRAIN;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last moved entry is written this cycle
        if (stat.act == pal_pkg::ACT_INSERT) begin
          state_next = S_PUT;
        end else begin
          cmd.del_done = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_PUT: begin
        cmd.write_val = 1'b1;
        state_next    = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_hit || stat.scan_miss) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### sv/positional_array_list.sv
// Words are handled one at a time: insert and delete shift one entry a cycle and
// search scans one entry a cycle; a new word is taken only once the last result
// has moved to the output register, and may be taken while that result waits.
// Reset: synchronous, active high; clears fill count, sequencer and out_valid;
// list memory is not cleared, only entries below the fill count are read.
// ----------------------------------------------------------------------------
// positional_array_list
// ordered list of signed words with insert, delete, search and read by position
// ----------------------------------------------------------------------------
module positional_array_list (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pal_pkg::ACT_W-1:0]         action,
  input  logic signed [pal_pkg::DATA_W-1:0] value,
  input  logic [pal_pkg::POS_W-1:0]         position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pal_pkg::ST_W-1:0]          status,
  output logic signed [pal_pkg::DATA_W-1:0] data,
  output logic [pal_pkg::POS_W-1:0]         where,
  output logic [pal_pkg::POS_W-1:0]         fill
);

  pal_pkg::pal_cmd_t  cmd;
  pal_pkg::pal_stat_t stat;

  // sequencer
  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and result path
  pal_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .action   (action),
    .value    (value),
    .position (position),
    .cmd      (cmd),
    .stat     (stat),
    .status   (status),
    .data     (data),
    .where    (where),
    .fill     (fill)
  );

endmodule

### tb/positional_array_list_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_array_list_tb
// streams insert, delete, search and read words into the list, keeps its own
// copy of the list contents and fill count, and checks every result word
// ----------------------------------------------------------------------------
module positional_array_list_tb;

  localparam int HALF_PERIOD = 4;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RECENT_MAX  = 48;

  localparam int CAPACITY = pal_pkg::CAPACITY;
  localparam int ACT_W    = pal_pkg::ACT_W;
  localparam int DATA_W   = pal_pkg::DATA_W;
  localparam int POS_W    = pal_pkg::POS_W;
  localparam int ST_W     = pal_pkg::ST_W;

  // entries of the stimulus queue: list words plus pacing markers
  typedef enum logic [1:0] {
    K_WORD,
    K_DRAIN,
    K_HOLD,
    K_QUIET
  } slot_kind_t;

  typedef struct {
    slot_kind_t                kind;
    pal_pkg::action_t          act;
    logic signed [DATA_W-1:0]  val;
    logic [POS_W-1:0]          pos;
  } list_word_t;

  typedef struct {
    pal_pkg::status_t          st;
    logic signed [DATA_W-1:0]  dat;
    logic [POS_W-1:0]          at;
    logic [POS_W-1:0]          cnt;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [ACT_W-1:0]          action = '0;
  logic signed [DATA_W-1:0]  value = '0;
  logic [POS_W-1:0]          position = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [ST_W-1:0]           status;
  logic signed [DATA_W-1:0]  data;
  logic [POS_W-1:0]          where;
  logic [POS_W-1:0]          fill;

  // bench state
  list_word_t                pending_words[$];
  list_result_t              results_due[$];
  logic signed [DATA_W-1:0]  model_vals [CAPACITY];
  int                        model_fill = 0;
  int                        words_total = 0;
  int                        words_taken = 0;
  int                        results_seen = 0;
  int                        mismatches = 0;
  int                        cycles = 0;
  int                        peak_fill = 0;
  int                        status_hits [5] = '{default: 0};
  logic                      hold_toggle = 1'b0;
  logic                      hold_seen = 1'b0;
  logic                      quiet = 1'b0;

  // planning side: fill count as the queued words will leave it
  int                        plan_fill = 0;
  logic signed [DATA_W-1:0]  recent_vals[$];

  always #HALF_PERIOD clk = ~clk;

  positional_array_list u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .value     (value),
    .position  (position),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .data      (data),
    .where     (where),
    .fill      (fill)
  );

  // list behaviour: update the bench copy and return the result word
  function automatic list_result_t apply_list_op(input pal_pkg::action_t act,
                                                 input logic signed [DATA_W-1:0] val,
                                                 input logic [POS_W-1:0] pos);
    list_result_t r;
    int           p;
    int           i;
    logic         hit;
    p     = int'(pos);
    hit   = 1'b0;
    r.st  = pal_pkg::ST_OK;
    r.dat = '0;
    r.at  = '0;
    case (act)
      pal_pkg::ACT_INSERT: begin
        if (model_fill >= CAPACITY) begin
          r.st = pal_pkg::ST_FULL;
        end else if (p < 1 || p > model_fill + 1) begin
          r.st = pal_pkg::ST_BADPOS;
        end else begin
          for (i = model_fill; i > p - 1; i--)
            model_vals[i] = model_vals[i-1];
          model_vals[p-1] = val;
          model_fill++;
          r.dat = val;
          r.at  = pos;
        end
      end
      pal_pkg::ACT_DELETE: begin
        if (model_fill == 0) begin
          r.st = pal_pkg::ST_EMPTY;
        end else if (p < 1 || p > model_fill) begin
          r.st = pal_pkg::ST_BADPOS;
        end else begin
          r.dat = model_vals[p-1];
          for (i = p - 1; i + 1 < model_fill; i++)
            model_vals[i] = model_vals[i+1];
          model_fill--;
          r.at = pos;
        end
      end
      pal_pkg::ACT_SEARCH: begin
        if (model_fill == 0) begin
          r.st = pal_pkg::ST_EMPTY;
        end else begin
          // lowest matching position wins
          for (i = 0; i < model_fill && !hit; i++) begin
            if (model_vals[i] == val) begin
              hit   = 1'b1;
              r.dat = val;
              r.at  = POS_W'(i + 1);
            end
          end
          if (!hit)
            r.st = pal_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        if (model_fill == 0) begin
          r.st = pal_pkg::ST_EMPTY;
        end else if (p < 1 || p > model_fill) begin
          r.st = pal_pkg::ST_BADPOS;
        end else begin
          r.dat = model_vals[p-1];
          r.at  = pos;
        end
      end
    endcase
    r.cnt = POS_W'(model_fill);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatches++;
    $display("%0t: result %0d: %s got %0h expected %0h", $time, results_seen, what,
             got, want);
  endtask

  // queue one list word and track the fill it leaves behind
  task automatic plan_word(input pal_pkg::action_t act,
                           input logic signed [DATA_W-1:0] val, input int pos);
    list_word_t               w;
    logic signed [DATA_W-1:0] old;
    w.kind = K_WORD;
    w.act  = act;
    w.val  = val;
    w.pos  = POS_W'(pos);
    pending_words.push_back(w);
    words_total++;
    if (act == pal_pkg::ACT_INSERT && plan_fill < CAPACITY &&
        pos >= 1 && pos <= plan_fill + 1) begin
      plan_fill++;
      recent_vals.push_back(val);
      if (recent_vals.size() > RECENT_MAX)
        old = recent_vals.pop_front();
    end else if (act == pal_pkg::ACT_DELETE && pos >= 1 && pos <= plan_fill) begin
      plan_fill--;
    end
  endtask

  task automatic plan_marker(input slot_kind_t kind);
    list_word_t w;
    w.kind = kind;
    w.act  = pal_pkg::ACT_READ;
    w.val  = '0;
    w.pos  = '0;
    pending_words.push_back(w);
  endtask

  // random word, mostly at legal positions, values often reused for searches
  task automatic plan_random_word(input int ins_pct, input int del_pct);
    int                       r;
    int                       hi;
    int                       pos;
    pal_pkg::action_t         act;
    logic signed [DATA_W-1:0] val;
    r = $urandom_range(0, 99);
    if (r < ins_pct)
      act = pal_pkg::ACT_INSERT;
    else if (r < ins_pct + del_pct)
      act = pal_pkg::ACT_DELETE;
    else if (r < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2)
      act = pal_pkg::ACT_SEARCH;
    else
      act = pal_pkg::ACT_READ;
    hi = (act == pal_pkg::ACT_INSERT) ? plan_fill + 1 : plan_fill;
    r  = $urandom_range(0, 99);
    if (hi < 1 || r >= 85)
      pos = $urandom_range(0, 255);
    else if (r < 10)
      pos = 1;
    else if (r < 20)
      pos = hi;
    else
      pos = $urandom_range(1, hi);
    r = $urandom_range(0, 99);
    if (recent_vals.size() != 0 && (r < 25 || (act == pal_pkg::ACT_SEARCH && r < 70))) begin
      val = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
    end else if (r < 33) begin
      case ($urandom_range(0, 3))
        0:       val = 32'sh8000_0000;
        1:       val = 32'sh7fff_ffff;
        2:       val = '0;
        default: val = -32'sd1;
      endcase
    end else begin
      val = $signed($urandom);
    end
    plan_word(act, val, pos);
  endtask

  // driver: offers queued words, handles pacing markers
  always @(posedge clk) begin : drive_proc
    list_word_t w;
    logic       nxt_valid;
    int         gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        results_due.push_back(apply_list_op(pal_pkg::action_t'(action), value, position));
        words_taken++;
      end
      nxt_valid = in_valid && !in_ready;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() != 0) begin
          w = pending_words[0];
          case (w.kind)
            K_DRAIN: begin
              if (results_due.size() == 0)
                w = pending_words.pop_front();
            end
            K_HOLD: begin
              hold_toggle <= ~hold_toggle;
              w = pending_words.pop_front();
            end
            K_QUIET: begin
              quiet <= 1'b1;
              w = pending_words.pop_front();
            end
            default: begin
              if (!quiet && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(0, 4);
              end else begin
                w = pending_words.pop_front();
                nxt_valid = 1'b1;
                action   <= w.act;
                value    <= w.val;
                position <= w.pos;
              end
            end
          endcase
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // monitor: checks result words and paces out_ready
  always @(posedge clk) begin : watch_proc
    list_result_t e;
    logic         nxt_ready;
    int           hold_left;
    int           stall_left;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left  = 0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          report_mismatch("result word with none awaited, status", status, '0);
        end else begin
          e = results_due.pop_front();
          if (status !== e.st)
            report_mismatch("status", status, e.st);
          if (data !== e.dat)
            report_mismatch("data", data, e.dat);
          if (where !== e.at)
            report_mismatch("where", where, e.at);
          if (fill !== e.cnt)
            report_mismatch("fill", fill, e.cnt);
          status_hits[int'(e.st)]++;
          if (int'(e.cnt) > peak_fill)
            peak_fill = int'(e.cnt);
        end
      end
      // long hold-off on request, otherwise short random stalls
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      nxt_ready = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 4);
        nxt_ready  = 1'b0;
      end
      out_ready <= nxt_ready;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("positional_array_list_tb: timeout after %0d cycles", cycles);
      $display("positional_array_list_tb: FAIL");
      $finish;
    end
  end

  // stimulus plan, reset and end of run
  initial begin : plan_proc
    int k;
    // empty list cases and bad positions
    plan_word(pal_pkg::ACT_READ, 32'sd0, 1);
    plan_word(pal_pkg::ACT_DELETE, 32'sd0, 1);
    plan_word(pal_pkg::ACT_SEARCH, 32'sd0, 0);
    plan_word(pal_pkg::ACT_INSERT, 32'sd5, 0);
    plan_word(pal_pkg::ACT_INSERT, 32'sd5, 2);
    // value extremes, insert at front and at the end
    plan_word(pal_pkg::ACT_INSERT, 32'sh8000_0000, 1);
    plan_word(pal_pkg::ACT_INSERT, 32'sh7fff_ffff, 2);
    plan_word(pal_pkg::ACT_INSERT, -32'sd1, 1);
    plan_word(pal_pkg::ACT_INSERT, 32'sd7, 255);
    plan_word(pal_pkg::ACT_INSERT, -32'sd1, 4);
    plan_word(pal_pkg::ACT_READ, 32'sd0, 0);
    plan_word(pal_pkg::ACT_READ, 32'sd0, 4);
    plan_word(pal_pkg::ACT_READ, 32'sd0, 5);
    // duplicate search returns the lowest position
    plan_word(pal_pkg::ACT_SEARCH, -32'sd1, 9);
    plan_word(pal_pkg::ACT_SEARCH, 32'sh7fff_ffff, 0);
    plan_word(pal_pkg::ACT_SEARCH, 32'sd0, 0);
    plan_word(pal_pkg::ACT_DELETE, 32'sd0, 0);
    plan_word(pal_pkg::ACT_DELETE, 32'sd0, 5);
    plan_word(pal_pkg::ACT_DELETE, 32'sd0, 2);
    plan_word(pal_pkg::ACT_DELETE, 32'sd0, 3);
    plan_word(pal_pkg::ACT_INSERT, 32'sh5555_5555, 2);
    plan_word(pal_pkg::ACT_READ, 32'sd0, 2);
    plan_word(pal_pkg::ACT_DELETE, -32'sd1, 1);
    plan_word(pal_pkg::ACT_READ, 32'sd0, 128);
    // mixed traffic with one long receiver hold-off
    for (k = 0; k < 280; k++) begin
      if (k == 30)
        plan_marker(K_HOLD);
      plan_random_word(40, 25);
    end
    // grow until full, then knock on the full list
    for (k = 0; k < 220; k++)
      plan_random_word(80, 5);
    while (plan_fill < CAPACITY)
      plan_random_word(100, 0);
    for (k = 0; k < 12; k++)
      plan_random_word(60, 10);
    plan_marker(K_DRAIN);
    // shrink until empty, then poke the empty list
    for (k = 0; k < 250; k++)
      plan_random_word(10, 65);
    while (plan_fill > 0)
      plan_random_word(0, 100);
    for (k = 0; k < 10; k++)
      plan_random_word(0, 40);
    for (k = 0; k < 300; k++) begin
      if (k == 150)
        plan_marker(K_HOLD);
      plan_random_word(35, 30);
    end
    plan_marker(K_DRAIN);
    // closing stretch without idling
    plan_marker(K_QUIET);
    for (k = 0; k < 200; k++)
      plan_random_word(35, 30);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (words_taken < words_total || results_due.size() != 0)
      @(posedge clk);
    repeat (CAPACITY + 10) @(posedge clk);

    $display("positional_array_list_tb: %0d words sent, %0d results checked, %0d mismatches,",
             words_taken, results_seen, mismatches);
    $display("positional_array_list_tb: peak fill %0d, ok %0d, full %0d, empty %0d,",
             peak_fill, status_hits[0], status_hits[1], status_hits[2]);
    $display("positional_array_list_tb: bad position %0d, not found %0d",
             status_hits[3], status_hits[4]);
    if (mismatches == 0)
      $display("positional_array_list_tb: PASS");
    else
      $display("positional_array_list_tb: FAIL");
    $finish;
  end

endmodule

### positional_array_list.f
+incdir+sv
sv/pal_pkg.sv
sv/pal_dp.sv
sv/pal_ctrl.sv
sv/positional_array_list.sv
tb/positional_array_list_tb.sv
